[rtl/sgr_pkg.sv]
`timescale 1ns / 1ps
// Package for the SGR colour tracker: byte codes, phase encoding, colour
// and result types, parameter default. No dependencies.
package sgr_pkg;

  localparam int MAX_BODY_BYTES_DEF = 16;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam int TOKEN_W = 7;
  localparam logic [TOKEN_W-1:0] TOKEN_SAT = 7'd127;

  localparam logic [TOKEN_W-1:0] CODE_RESET  = 7'd0;
  localparam logic [TOKEN_W-1:0] CODE_FG_LO  = 7'd30;
  localparam logic [TOKEN_W-1:0] CODE_FG_HI  = 7'd37;
  localparam logic [TOKEN_W-1:0] CODE_BG_LO  = 7'd40;
  localparam logic [TOKEN_W-1:0] CODE_BG_HI  = 7'd47;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_TYPE = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] idx;
  } color_t;

  localparam color_t COLOR_UNSET = '{vld: 1'b0, idx: 3'd0};

  typedef struct packed {
    logic       fg_valid;
    logic [2:0] fg_color;
    logic       bg_valid;
    logic [2:0] bg_color;
    logic       committed;
  } sgr_result_t;

endpackage

[rtl/sgr_if.sv]
`timescale 1ns / 1ps
// Stream interfaces for the SGR colour tracker: byte input and colour result.
// Valid/ready handshake; no package dependency.
interface sgr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface sgr_color_if;
  logic       valid;
  logic       ready;
  logic       fg_valid;
  logic [2:0] fg_color;
  logic       bg_valid;
  logic [2:0] bg_color;
  logic       committed;

  modport source (output valid, output fg_valid, output fg_color, output bg_valid,
                  output bg_color, output committed, input ready);
  modport sink   (input valid, input fg_valid, input fg_color, input bg_valid,
                  input bg_color, input committed, output ready);
endinterface

[rtl/sgr_parser.sv]
`timescale 1ns / 1ps
// Escape sequence parser: holds parse and colour state, computes the result
// for one byte. Depends on sgr_pkg.
module sgr_parser #(
  parameter int MAX_BODY_BYTES = sgr_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output sgr_pkg::sgr_result_t result
);
  import sgr_pkg::*;

  localparam int BL_W = $clog2(MAX_BODY_BYTES + 1);
  localparam logic [BL_W-1:0] BL_MAX = BL_W'(MAX_BODY_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [BL_W-1:0]   blen_r, blen_nxt;
  logic [TOKEN_W-1:0] tok_r, tok_nxt;
  logic              tok_dig_r, tok_dig_nxt;
  logic              err_r, err_nxt;
  color_t            pfg_r, pfg_nxt, pbg_r, pbg_nxt;
  color_t            cfg_r, cfg_nxt, cbg_r, cbg_nxt;

  // token close: apply the finished parameter to the pending colours
  color_t            pfg_cl, pbg_cl;
  logic [10:0]       acc;
  logic [BL_W-1:0]   blen_inc;
  logic              commit;

  always_comb begin
    pfg_cl = pfg_r;
    pbg_cl = pbg_r;
    if (tok_dig_r && !err_r) begin
      if (tok_r == CODE_RESET) begin
        pfg_cl = COLOR_UNSET;
        pbg_cl = COLOR_UNSET;
      end else if (tok_r inside {[CODE_FG_LO:CODE_FG_HI]}) begin
        pfg_cl = '{vld: 1'b1, idx: 3'(tok_r - CODE_FG_LO)};
      end else if (tok_r inside {[CODE_BG_LO:CODE_BG_HI]}) begin
        pbg_cl = '{vld: 1'b1, idx: 3'(tok_r - CODE_BG_LO)};
      end
    end
  end

  // tok*10 + digit, at most 1279
  assign acc = {1'b0, tok_r, 3'b000} + {3'b000, tok_r, 1'b0}
             + {7'd0, 4'(byte_in - CH_0)};
  assign blen_inc = blen_r + BL_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    blen_nxt    = blen_r;
    tok_nxt     = tok_r;
    tok_dig_nxt = tok_dig_r;
    err_nxt     = err_r;
    pfg_nxt     = pfg_r;
    pbg_nxt     = pbg_r;
    cfg_nxt     = cfg_r;
    cbg_nxt     = cbg_r;
    commit      = 1'b0;
    case (phase_r)
      PH_TYPE: begin
        if (byte_in == CH_LBRKT) begin
          phase_nxt   = PH_BODY;
          blen_nxt    = '0;
          tok_nxt     = '0;
          tok_dig_nxt = 1'b0;
          err_nxt     = 1'b0;
          pfg_nxt     = cfg_r;
          pbg_nxt     = cbg_r;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_BODY: begin
        if (byte_in == CH_M) begin
          tok_nxt     = '0;
          tok_dig_nxt = 1'b0;
          pfg_nxt     = pfg_cl;
          pbg_nxt     = pbg_cl;
          if (err_r) begin
            cfg_nxt = COLOR_UNSET;
            cbg_nxt = COLOR_UNSET;
          end else begin
            cfg_nxt = pfg_cl;
            cbg_nxt = pbg_cl;
          end
          commit    = 1'b1;
          phase_nxt = PH_WAIT;
        end else begin
          if (byte_in inside {[CH_0:CH_9]}) begin
            tok_nxt     = (acc > 11'(TOKEN_SAT)) ? TOKEN_SAT : acc[TOKEN_W-1:0];
            tok_dig_nxt = 1'b1;
          end else if (byte_in == CH_SEMI) begin
            tok_nxt     = '0;
            tok_dig_nxt = 1'b0;
            pfg_nxt     = pfg_cl;
            pbg_nxt     = pbg_cl;
          end else begin
            err_nxt = 1'b1;
          end
          blen_nxt = blen_inc;
          if (blen_inc >= BL_MAX) phase_nxt = PH_WAIT;
        end
      end
      default: begin
        // waiting, and any stray phase code
        phase_nxt = (byte_in == CH_ESC) ? PH_TYPE : PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      blen_r    <= '0;
      tok_r     <= '0;
      tok_dig_r <= 1'b0;
      err_r     <= 1'b0;
      pfg_r     <= COLOR_UNSET;
      pbg_r     <= COLOR_UNSET;
      cfg_r     <= COLOR_UNSET;
      cbg_r     <= COLOR_UNSET;
    end else if (step) begin
      phase_r   <= phase_nxt;
      blen_r    <= blen_nxt;
      tok_r     <= tok_nxt;
      tok_dig_r <= tok_dig_nxt;
      err_r     <= err_nxt;
      pfg_r     <= pfg_nxt;
      pbg_r     <= pbg_nxt;
      cfg_r     <= cfg_nxt;
      cbg_r     <= cbg_nxt;
    end
  end

  assign result.fg_valid  = cfg_nxt.vld;
  assign result.fg_color  = cfg_nxt.vld ? cfg_nxt.idx : 3'd0;
  assign result.bg_valid  = cbg_nxt.vld;
  assign result.bg_color  = cbg_nxt.vld ? cbg_nxt.idx : 3'd0;
  assign result.committed = commit;

endmodule

[rtl/ansi_sgr_color_parser.sv]
`timescale 1ns / 1ps
// SGR colour tracker, top level. An input beat reaches its result beat through
// the input register, then the result register. Throughput: one byte per cycle
// while the receiver does not hold ready low; the parser steps once per byte.
// Synchronous active-low reset: colours unset, parser waiting for ESC, both
// registers empty. Depends on sgr_pkg, sgr_if and sgr_parser.
module ansi_sgr_color_parser #(
  parameter int MAX_BODY_BYTES = sgr_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sgr_byte_if.sink    in_bus,
  sgr_color_if.source out_bus
);
  import sgr_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  // result register
  logic        out_valid_r;
  sgr_result_t out_res_r;

  sgr_result_t res;
  logic        adv;

  // the held byte moves on when the result register is free or being drained
  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  sgr_parser #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_in (s1_byte_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) s1_byte_r <= in_bus.byte_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.fg_valid  = out_res_r.fg_valid;
  assign out_bus.fg_color  = out_res_r.fg_color;
  assign out_bus.bg_valid  = out_res_r.bg_valid;
  assign out_bus.bg_color  = out_res_r.bg_color;
  assign out_bus.committed = out_res_r.committed;

endmodule

[tb/ansi_sgr_color_parser_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for ansi_sgr_color_parser: byte beats in, colour beats out.
// Uses sgr_pkg, the sgr_byte_if / sgr_color_if interfaces and the block itself.
module ansi_sgr_color_parser_test;
  import sgr_pkg::*;

  // Body limit the block is built with (default parameter).
  localparam int BODY_LIMIT = MAX_BODY_BYTES_DEF;
  // Result beat trails its input beat by two stages; allow a margin on top.
  localparam int DRAIN_CYCLES = 8;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int LONG_HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Bench-side drive registers, known from time zero.
  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       rcv_ready = 1'b0;

  sgr_byte_if  in_bus();
  sgr_color_if out_bus();

  assign in_bus.valid   = drv_valid;
  assign in_bus.byte_in = drv_byte;
  assign out_bus.ready  = rcv_ready;

  ansi_sgr_color_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Colour tracker: the bench's own copy of the parser state.
  // ------------------------------------------------------------------
  phase_t         trk_phase     = PH_WAIT;
  int             trk_len       = 0;
  logic [6:0]     trk_tok       = 7'd0;
  logic           trk_has_digit = 1'b0;
  logic           trk_bad       = 1'b0;
  color_t         trk_pend_fg   = COLOR_UNSET;
  color_t         trk_pend_bg   = COLOR_UNSET;
  color_t         trk_cur_fg    = COLOR_UNSET;
  color_t         trk_cur_bg    = COLOR_UNSET;

  // One SGR code onto the pending colours; unknown codes fall through.
  function automatic void apply_sgr_code(input logic [6:0] code);
    logic [6:0] ofs;
    if (code == CODE_RESET) begin
      trk_pend_fg = COLOR_UNSET;
      trk_pend_bg = COLOR_UNSET;
    end else if (code >= CODE_FG_LO && code <= CODE_FG_HI) begin
      ofs = code - CODE_FG_LO;
      trk_pend_fg.vld = 1'b1;
      trk_pend_fg.idx = ofs[2:0];
    end else if (code >= CODE_BG_LO && code <= CODE_BG_HI) begin
      ofs = code - CODE_BG_LO;
      trk_pend_bg.vld = 1'b1;
      trk_pend_bg.idx = ofs[2:0];
    end
  endfunction

  // End of a parameter: empty ones and those of a spoilt sequence do nothing.
  function automatic void end_param();
    if (trk_has_digit && !trk_bad) apply_sgr_code(trk_tok);
    trk_tok       = 7'd0;
    trk_has_digit = 1'b0;
  endfunction

  // Advance the tracker by one byte and return the colour beat it should give.
  function automatic sgr_result_t track_byte(input logic [7:0] b);
    sgr_result_t r;
    logic        done;
    int          v;
    done = 1'b0;
    case (trk_phase)
      PH_TYPE: begin
        if (b == CH_LBRKT) begin
          trk_phase     = PH_BODY;
          trk_len       = 0;
          trk_tok       = 7'd0;
          trk_has_digit = 1'b0;
          trk_bad       = 1'b0;
          trk_pend_fg   = trk_cur_fg;
          trk_pend_bg   = trk_cur_bg;
        end else begin
          trk_phase = PH_WAIT;
        end
      end
      PH_BODY: begin
        if (b == CH_M) begin
          end_param();
          if (trk_bad) begin
            trk_cur_fg = COLOR_UNSET;
            trk_cur_bg = COLOR_UNSET;
          end else begin
            trk_cur_fg = trk_pend_fg;
            trk_cur_bg = trk_pend_bg;
          end
          done      = 1'b1;
          trk_phase = PH_WAIT;
        end else begin
          if (b >= CH_0 && b <= CH_9) begin
            // decimal accumulate, pinned at the saturation value
            v = int'(trk_tok) * 10 + int'(b - CH_0);
            trk_tok       = (v > int'(TOKEN_SAT)) ? TOKEN_SAT : v[6:0];
            trk_has_digit = 1'b1;
          end else if (b == CH_SEMI) begin
            end_param();
          end else begin
            trk_bad = 1'b1;
          end
          trk_len++;
          // overlong body: sequence abandoned, colours untouched
          if (trk_len >= BODY_LIMIT) trk_phase = PH_WAIT;
        end
      end
      default: begin
        trk_phase = (b == CH_ESC) ? PH_TYPE : PH_WAIT;
      end
    endcase
    r.fg_valid  = trk_cur_fg.vld;
    r.fg_color  = trk_cur_fg.vld ? trk_cur_fg.idx : 3'd0;
    r.bg_valid  = trk_cur_bg.vld;
    r.bg_color  = trk_cur_bg.vld ? trk_cur_bg.idx : 3'd0;
    r.committed = done;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus store and helpers.
  // ------------------------------------------------------------------
  logic [7:0]  byte_queue[$];
  sgr_result_t colors_due[$];
  int          n_queued = 0;
  int          mismatches = 0;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A body byte that is neither digit, separator nor terminator.
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = "+";
      1: b = "-";
      2: b = " ";
      3: b = 8'h00;
      default: begin
        b = 8'($urandom_range(0, 255));
        while ((b >= CH_0 && b <= CH_9) || b == CH_SEMI || b == CH_M)
          b = 8'($urandom_range(0, 255));
      end
    endcase
    return b;
  endfunction

  function automatic string fmt_colors(input sgr_result_t c);
    return $sformatf("fg %0b/%0d bg %0b/%0d commit %0b",
                     c.fg_valid, c.fg_color, c.bg_valid, c.bg_color, c.committed);
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    byte_queue = {byte_queue, b};
    n_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_decimal(input int value);
    queue_text($sformatf("%0d", value));
  endtask

  // One parameter: empty, a colour code, some other number, a huge one,
  // or one spoilt by a stray byte.
  task automatic add_param();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 8) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) queue_byte(CH_0);
      if (pick < 20) queue_decimal(0);
      else if (pick < 45) queue_decimal($urandom_range(30, 37));
      else if (pick < 70) queue_decimal($urandom_range(40, 47));
      else if (pick < 82) queue_decimal($urandom_range(1, 999));
      else if (pick < 88) queue_decimal($urandom_range(128, 99999));
      else begin
        if ($urandom_range(0, 1) == 0) queue_decimal($urandom_range(0, 47));
        queue_byte(junk_byte());
        if ($urandom_range(0, 1) == 0) queue_decimal($urandom_range(0, 47));
      end
    end
  endtask

  task automatic add_sgr_sequence(input logic terminate);
    int n_par;
    n_par = $urandom_range(0, 4);
    queue_byte(CH_ESC);
    queue_byte(CH_LBRKT);
    for (int i = 0; i < n_par; i++) begin
      if (i > 0) queue_byte(CH_SEMI);
      add_param();
    end
    if ($urandom_range(0, 7) == 0) queue_byte(CH_SEMI);
    if (terminate) queue_byte(CH_M);
  endtask

  // Body around the length limit: just under it commits, at it drops.
  task automatic add_long_body();
    int n;
    n = $urandom_range(BODY_LIMIT - 3, BODY_LIMIT + 4);
    queue_byte(CH_ESC);
    queue_byte(CH_LBRKT);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) queue_byte(CH_SEMI);
      else queue_byte(CH_0 + 8'($urandom_range(0, 9)));
    end
    queue_byte(CH_M);
  endtask

  task automatic add_random_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) add_sgr_sequence(1'b1);
    else if (r < 80) repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
    else if (r < 90) begin
      // ESC followed by another ESC or a junk byte, which can be the bracket
      queue_byte(CH_ESC);
      if ($urandom_range(0, 2) == 0) queue_byte(CH_ESC);
      else queue_byte(junk_byte());
    end else if (r < 96) add_long_body();
    else add_sgr_sequence(1'b0);  // cut short, next unit breaks in
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || drv_valid || colors_due.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Input side: prediction on accepted beats, driver at the falling edge.
  // ------------------------------------------------------------------
  bit in_took  = 1'b0;
  bit in_burst = 1'b0;
  int in_idle  = 0;

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      colors_due = {colors_due, track_byte(in_bus.byte_in)};
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_took) begin
      // free to move: either idle or the last beat just went in
      if (in_idle > 0) begin
        in_idle--;
        drv_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        drv_byte  <= byte_queue.pop_front();
        drv_valid <= 1'b1;
        if (!in_burst) in_idle = idle_len();
      end else begin
        drv_valid <= 1'b0;
      end
    end
    in_took = 1'b0;
    if ($urandom_range(0, 149) == 0) in_burst = !in_burst;
  end

  // ------------------------------------------------------------------
  // Output side: ready pattern at the falling edge, checking at the rising.
  // ------------------------------------------------------------------
  bit          long_hold = 1'b0;
  bit          hold_go   = 1'b0;
  bit          out_burst = 1'b0;
  int          out_idle  = 0;
  logic        rdy_next;
  sgr_result_t mon_got;
  sgr_result_t mon_exp;

  always @(negedge clk) begin
    if (!rst_n || long_hold) begin
      rdy_next = 1'b0;
    end else if (out_idle > 0) begin
      out_idle--;
      rdy_next = 1'b0;
    end else begin
      rdy_next = 1'b1;
      if (!out_burst && $urandom_range(0, 3) == 0) out_idle = idle_len();
    end
    if ($urandom_range(0, 199) == 0) out_burst = !out_burst;
    rcv_ready <= rdy_next;
  end

  // Long receiver hold-off so the pipe fills and back-pressures the input.
  initial begin
    while (!hold_go) @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      mon_got.fg_valid  = out_bus.fg_valid;
      mon_got.fg_color  = out_bus.fg_color;
      mon_got.bg_valid  = out_bus.bg_valid;
      mon_got.bg_color  = out_bus.bg_color;
      mon_got.committed = out_bus.committed;
      if (colors_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with none expected: %s", $realtime, fmt_colors(mon_got));
        mismatches++;
      end else begin
        mon_exp = colors_due.pop_front();
        if (mon_got.fg_valid !== mon_exp.fg_valid || mon_got.fg_color !== mon_exp.fg_color ||
            mon_got.bg_valid !== mon_exp.bg_valid || mon_got.bg_color !== mon_exp.bg_color ||
            mon_got.committed !== mon_exp.committed) begin
          if (mismatches < 10)
            $display("%0t: mismatch, expected %s, got %s", $realtime,
                     fmt_colors(mon_exp), fmt_colors(mon_got));
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequencing of the run.
  // ------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme codes, reset code, leading zeros, empty parameter,
    // saturated value, ESC then a stray byte (0xFF), sign plus NUL in body.
    queue_text("\033[37;40m");
    queue_text("\033[0;030;;200;47m");
    queue_byte(CH_ESC);
    queue_byte(8'hFF);
    queue_text("\033[+");
    queue_byte(8'h00);
    queue_byte(CH_M);

    // sender stands back until every expected beat is in
    wait_drained();

    while (n_queued < 720) add_random_unit();
    wait_drained();

    // second half starts under the long receiver hold-off
    hold_go = 1'b1;
    while (n_queued < 1430) add_random_unit();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** ansi_sgr_color_parser: PASSED **");
    end else begin
      $display("** ansi_sgr_color_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legitimate run.
  initial begin
    #8_000_000;
    $display("** ansi_sgr_color_parser: FAILED **");
    $finish;
  end

endmodule

[sim.f]
rtl/sgr_pkg.sv
rtl/sgr_if.sv
rtl/sgr_parser.sv
rtl/ansi_sgr_color_parser.sv
tb/ansi_sgr_color_parser_test.sv
